// ===== sv/lps_pkg.sv =====
// shared types and constants of the led pattern sequencer
`timescale 1ns / 1ps

package lps_pkg;

    localparam int IN_DATA_W  = 88;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 88;
    localparam int OUT_USER_W = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [7:0] MS_PER_FADE_RESET = 8'd10;
    localparam logic [0:0] REG_MS_PER_FADE_UNIT = 1'b0;

    typedef enum logic [2:0] {
        REQ_TICK    = 3'd0,
        REQ_WRITE   = 3'd1,
        REQ_READ    = 3'd2,
        REQ_PLAY    = 3'd3,
        REQ_STATUS  = 3'd4,
        REQ_SET_LED = 3'd5,
        REQ_STOP    = 3'd6,
        REQ_UNUSED  = 3'd7
    } req_e;

    typedef enum logic [1:0] {
        KIND_FADE     = 2'd0,
        KIND_READBACK = 2'd1,
        KIND_STATUS   = 2'd2
    } kind_e;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } ctrl_state_t;

    // input item payload, red in the lowest bits
    typedef struct packed {
        logic [7:0]  led_in;
        logic [7:0]  count_in;
        logic [7:0]  end_in;
        logic [7:0]  start_in;
        logic [7:0]  mode_in;
        logic [7:0]  position;
        logic [15:0] fade_time;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } req_t;

    // result item payload, out_red in the lowest bits
    typedef struct packed {
        logic [7:0]  out_pos;
        logic [7:0]  out_count;
        logic [7:0]  out_end;
        logic [7:0]  out_start;
        logic [7:0]  out_mode;
        logic [7:0]  out_led;
        logic [15:0] out_fade;
        logic [7:0]  out_blue;
        logic [7:0]  out_green;
        logic [7:0]  out_red;
    } res_t;

    typedef struct packed {
        logic [7:0]  led;
        logic [15:0] fade;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } line_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic need_result;
        logic out_free;
    } sts_t;

endpackage

// ===== sv/lps_table.sv =====
// pattern table memory with per-line valid bits, registered read
`timescale 1ns / 1ps

module lps_table #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output lps_pkg::line_t       rd_line,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  lps_pkg::line_t       wr_line
);
    import lps_pkg::*;

    line_t            mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    line_t            rd_data_reg;
    logic             rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_line;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // a line never written reads as all zero
    assign rd_line = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== sv/lps_ctrl.sv =====
// controller state machine: accept an item, then execute it, waiting for a free output if it produces a result
`timescale 1ns / 1ps

module lps_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  lps_pkg::sts_t        sts,
    output lps_pkg::cmd_t        cmd,
    output lps_pkg::ctrl_state_t state
);
    import lps_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // hold while a result is due and the output register is still full
                if (!sts.need_result || sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign state = state_reg;

endmodule

// ===== sv/lps_datapath.sv =====
// datapath: request latch, player state, table access and output register
`timescale 1ns / 1ps

module lps_datapath #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  lps_pkg::cmd_t                    cmd,
    output lps_pkg::sts_t                    sts,
    input  logic [lps_pkg::IN_USER_W-1:0]    s_user,
    input  lps_pkg::req_t                    s_req,
    input  logic [7:0]                       ms_per_fade_unit,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [lps_pkg::OUT_USER_W-1:0]   m_user,
    output lps_pkg::res_t                    m_res
);
    import lps_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    req_e        req_type_reg;
    req_t        req_reg;

    logic [7:0]  play_mode_reg,  play_mode_next;
    logic [7:0]  play_pos_reg,   play_pos_next;
    logic [7:0]  play_start_reg, play_start_next;
    logic [7:0]  play_end_reg,   play_end_next;
    logic [7:0]  loops_left_reg, loops_left_next;
    logic [7:0]  held_led_reg,   held_led_next;
    logic [31:0] elapsed_reg,    elapsed_next;
    logic [31:0] deadline_reg,   deadline_next;

    logic        out_valid_reg;
    kind_e       out_kind_reg,   out_kind_next;
    res_t        out_res_reg,    out_res_next;

    logic [AW-1:0] mod_lut [256];
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    line_t         rd_line;
    line_t         wr_line;
    logic          wr_en;

    logic [31:0] elapsed_inc;
    logic [31:0] diff;
    logic        due;
    logic        line_nonzero;
    logic [7:0]  pos_inc;
    logic [7:0]  loops_dec;
    logic [23:0] fade_product;
    logic [8:0]  end_wide;
    logic        load_out;

    // play position modulo table depth, worked out at elaboration
    for (genvar i = 0; i < 256; i++) begin : g_mod
        assign mod_lut[i] = AW'(i % TABLE_DEPTH);
    end

    function automatic logic [AW-1:0] line_index(input logic [7:0] p);
        logic [AW-1:0] idx;
        if ({1'b0, p} >= 9'(TABLE_DEPTH)) begin
            idx = '0;
        end else begin
            idx = p[AW-1:0];
        end
        return idx;
    endfunction

    assign rd_addr = (req_e'(s_user) == REQ_TICK) ? mod_lut[play_pos_reg]
                                                  : line_index(s_req.position);
    assign wr_addr = line_index(req_reg.position);
    assign wr_line = '{led: held_led_reg, fade: req_reg.fade_time, blue: req_reg.blue,
                       green: req_reg.green, red: req_reg.red};
    assign wr_en   = cmd.commit && (req_type_reg == REQ_WRITE);

    lps_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (cmd.capture),
        .rd_addr (rd_addr),
        .rd_line (rd_line),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_line (wr_line)
    );

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_type_reg <= req_e'(s_user);
            req_reg      <= s_req;
        end
    end

    // tick arithmetic
    assign elapsed_inc  = elapsed_reg + 32'd1;
    assign diff         = elapsed_inc - deadline_reg;
    assign due          = (play_mode_reg != 8'd0) && (diff != 32'd0) && !diff[31];
    assign line_nonzero = (rd_line.fade != 16'd0) || (rd_line.red != 8'd0) ||
                          (rd_line.green != 8'd0) || (rd_line.blue != 8'd0);
    assign pos_inc      = play_pos_reg + 8'd1;
    assign loops_dec    = loops_left_reg - 8'd1;
    assign fade_product = 24'(rd_line.fade) * 24'(ms_per_fade_unit);
    assign end_wide     = {1'b0, req_reg.end_in};

    always_comb begin
        sts.need_result = 1'b0;
        sts.out_free    = !out_valid_reg || m_ready;
        case (req_type_reg)
            REQ_TICK:   sts.need_result = due && line_nonzero;
            REQ_READ:   sts.need_result = 1'b1;
            REQ_STATUS: sts.need_result = 1'b1;
            default:    sts.need_result = 1'b0;
        endcase
    end
    assign load_out     = cmd.commit && sts.need_result;

    always_comb begin
        play_mode_next  = play_mode_reg;
        play_pos_next   = play_pos_reg;
        play_start_next = play_start_reg;
        play_end_next   = play_end_reg;
        loops_left_next = loops_left_reg;
        held_led_next   = held_led_reg;
        elapsed_next    = elapsed_reg;
        deadline_next   = deadline_reg;
        out_kind_next   = out_kind_reg;
        out_res_next    = out_res_reg;

        if (cmd.commit) begin
            case (req_type_reg)
                REQ_TICK: begin
                    elapsed_next = elapsed_inc;
                    if (due) begin
                        play_pos_next = pos_inc;
                        if (pos_inc == play_end_reg) begin
                            play_pos_next   = play_start_reg;
                            loops_left_next = loops_dec;
                            if (loops_dec == 8'd0) begin
                                play_mode_next = 8'd0;
                            end else if (loops_dec == 8'd255) begin
                                // infinite play keeps its zero count
                                loops_left_next = 8'd0;
                            end
                        end
                        deadline_next = deadline_reg + 32'(fade_product);
                    end
                end
                REQ_PLAY: begin
                    play_mode_next  = req_reg.mode_in;
                    play_start_next = req_reg.start_in;
                    play_pos_next   = req_reg.start_in;
                    loops_left_next = req_reg.count_in;
                    deadline_next   = elapsed_reg;
                    if ((end_wide == 9'd0) || (end_wide > 9'(TABLE_DEPTH))) begin
                        play_end_next = 8'(TABLE_DEPTH);
                    end else begin
                        play_end_next = 8'(end_wide + 9'd1);
                    end
                end
                REQ_SET_LED: begin
                    held_led_next = req_reg.led_in;
                end
                REQ_STOP: begin
                    play_mode_next = 8'd0;
                end
                default: begin
                end
            endcase
        end

        if (load_out) begin
            out_res_next = '0;
            if (req_type_reg == REQ_STATUS) begin
                out_kind_next          = KIND_STATUS;
                out_res_next.out_mode  = play_mode_reg;
                out_res_next.out_start = play_start_reg;
                out_res_next.out_end   = play_end_reg;
                out_res_next.out_count = loops_left_reg;
                out_res_next.out_pos   = play_pos_reg;
            end else begin
                out_kind_next          = (req_type_reg == REQ_READ) ? KIND_READBACK
                                                                    : KIND_FADE;
                out_res_next.out_red   = rd_line.red;
                out_res_next.out_green = rd_line.green;
                out_res_next.out_blue  = rd_line.blue;
                out_res_next.out_fade  = rd_line.fade;
                out_res_next.out_led   = rd_line.led;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            play_mode_reg  <= 8'd0;
            play_pos_reg   <= 8'd0;
            play_start_reg <= 8'd0;
            play_end_reg   <= 8'(TABLE_DEPTH);
            loops_left_reg <= 8'd0;
            held_led_reg   <= 8'd0;
            elapsed_reg    <= 32'd0;
            deadline_reg   <= 32'd0;
            out_valid_reg  <= 1'b0;
        end else begin
            play_mode_reg  <= play_mode_next;
            play_pos_reg   <= play_pos_next;
            play_start_reg <= play_start_next;
            play_end_reg   <= play_end_next;
            loops_left_reg <= loops_left_next;
            held_led_reg   <= held_led_next;
            elapsed_reg    <= elapsed_next;
            deadline_reg   <= deadline_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_kind_reg <= out_kind_next;
        out_res_reg  <= out_res_next;
    end

    assign m_valid = out_valid_reg;
    assign m_user  = out_kind_reg;
    assign m_res   = out_res_reg;

endmodule

// ===== sv/led_pattern_sequencer_core.sv =====
// top level of the led pattern sequencer: stream channels, register port, controller and datapath
`timescale 1ns / 1ps

// Pattern table player. Each accepted item (a millisecond tick or a request) is first
// accepted, which reads the pattern table whose read data is registered, and then executed
// against the player state. The result register parts the two channels, so the next item
// is accepted while a result waits; an item that produces a result stays in its execute
// state until that register is free. The table resets to all zero through one valid bit
// per line, so no clearing pass runs after reset.
// Register ms_per_fade_unit (reset 10) lies at byte address 0 of the register port.
module led_pattern_sequencer_core #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // red[7:0] green[15:8] blue[23:16] fade_time[39:24] position[47:40]
    // mode_in[55:48] start_in[63:56] end_in[71:64] count_in[79:72] led_in[87:80]
    input  logic [lps_pkg::IN_DATA_W-1:0]      s_tdata,
    // req_type[2:0]
    input  logic [lps_pkg::IN_USER_W-1:0]      s_tuser,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // out_red[7:0] out_green[15:8] out_blue[23:16] out_fade[39:24] out_led[47:40]
    // out_mode[55:48] out_start[63:56] out_end[71:64] out_count[79:72] out_pos[87:80]
    output logic [lps_pkg::OUT_DATA_W-1:0]     m_tdata,
    // result_kind[1:0]
    output logic [lps_pkg::OUT_USER_W-1:0]     m_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lps_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [lps_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [lps_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import lps_pkg::*;

    logic [7:0]  ms_per_fade_unit_reg;
    cmd_t        cmd;
    sts_t        sts;
    ctrl_state_t ctrl_state;
    res_t        m_res;
    logic        reg_sel;

    // register index is the word address
    assign reg_sel = (paddr[CFG_ADDR_W-1] == REG_MS_PER_FADE_UNIT);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {24'd0, ms_per_fade_unit_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ms_per_fade_unit_reg <= MS_PER_FADE_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            ms_per_fade_unit_reg <= pwdata[7:0];
        end
    end

    lps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd),
        .state    (ctrl_state)
    );

    lps_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .s_user           (s_tuser),
        .s_req            (req_t'(s_tdata)),
        .ms_per_fade_unit (ms_per_fade_unit_reg),
        .m_valid          (m_tvalid),
        .m_ready          (m_tready),
        .m_user           (m_tuser),
        .m_res            (m_res)
    );

    assign m_tdata = m_res;

    a_accept_then_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (ctrl_state == ST_EXEC))
        else $error("accepted item did not move the controller to execute");

    a_result_from_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> ($past(ctrl_state) == ST_EXEC))
        else $error("result appeared without an execute cycle");

    a_status_no_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_STATUS)) |-> (m_tdata[47:0] == '0))
        else $error("status item carries line fields");

    a_line_no_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != KIND_STATUS)) |-> (m_tdata[87:48] == '0))
        else $error("line item carries player fields");

endmodule

// ===== bench/led_pattern_sequencer_checker.sv =====
// result checker for the led pattern sequencer: watches both streams and the register port
`timescale 1ns / 1ps

module led_pattern_sequencer_checker #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [lps_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic [lps_pkg::IN_USER_W-1:0]      s_tuser,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [lps_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic [lps_pkg::OUT_USER_W-1:0]     m_tuser,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lps_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [lps_pkg::CFG_DATA_W-1:0]     pwdata,
    input  logic [lps_pkg::CFG_DATA_W-1:0]     prdata,
    input  logic                               pready,
    output int unsigned                        expected_left,
    output int                                 fail_count
);

    import lps_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] MS_UNIT_ADDR = CFG_ADDR_W'(4 * REG_MS_PER_FADE_UNIT);
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        kind_e kind;
        res_t  data;
    } owed_result_t;

    owed_result_t owed_results[$];

    // shadow of the table and the player
    line_t       pattern [TABLE_DEPTH];
    logic [7:0]  cur_mode;
    logic [7:0]  cur_pos;
    logic [7:0]  loop_start;
    logic [7:0]  loop_end;
    logic [7:0]  loops_to_go;
    logic [7:0]  led_sel;
    logic [31:0] now_ms;
    logic [31:0] due_ms;
    logic [7:0]  ms_unit;

    task automatic report_mismatch(input string msg);
        if (fail_count < MAX_REPORTS)
            $display("mismatch at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    function automatic res_t line_result(input line_t ln);
        res_t r;
        r = '0;
        r.out_red   = ln.red;
        r.out_green = ln.green;
        r.out_blue  = ln.blue;
        r.out_fade  = ln.fade;
        r.out_led   = ln.led;
        return r;
    endfunction

    function automatic int unsigned line_slot(input logic [7:0] position);
        return (position >= TABLE_DEPTH) ? 0 : int'(position);
    endfunction

    task automatic push_result(input kind_e kind, input res_t data);
        owed_result_t o;
        o.kind = kind;
        o.data = data;
        owed_results.push_back(o);
    endtask

    task automatic predict_request(input req_e kind, input req_t rq);
        int unsigned idx;
        line_t       ln;
        logic [31:0] gap;
        res_t        st;
        case (kind)
            REQ_TICK: begin
                now_ms = now_ms + 32'd1;
                gap = now_ms - due_ms;
                if (cur_mode != 8'd0 && $signed(gap) > 0) begin
                    idx = cur_pos % TABLE_DEPTH;
                    ln = pattern[idx];
                    // all-zero lines advance the player but emit nothing
                    if ({ln.red, ln.green, ln.blue, ln.fade} != '0)
                        push_result(KIND_FADE, line_result(ln));
                    cur_pos = cur_pos + 8'd1;
                    if (cur_pos == loop_end) begin
                        cur_pos = loop_start;
                        loops_to_go = loops_to_go - 8'd1;
                        if (loops_to_go == 8'd0)
                            cur_mode = 8'd0;
                        else if (loops_to_go == 8'hFF)
                            loops_to_go = 8'd0;
                    end
                    due_ms = due_ms + 32'(ln.fade) * 32'(ms_unit);
                end
            end
            REQ_WRITE: begin
                idx = line_slot(rq.position);
                pattern[idx].red   = rq.red;
                pattern[idx].green = rq.green;
                pattern[idx].blue  = rq.blue;
                pattern[idx].fade  = rq.fade_time;
                pattern[idx].led   = led_sel;
            end
            REQ_READ: begin
                push_result(KIND_READBACK, line_result(pattern[line_slot(rq.position)]));
            end
            REQ_PLAY: begin
                cur_mode = rq.mode_in;
                loop_start = rq.start_in;
                if (rq.end_in == 8'd0 || rq.end_in > TABLE_DEPTH)
                    loop_end = 8'(TABLE_DEPTH);
                else
                    loop_end = 8'(rq.end_in + 8'd1);
                loops_to_go = rq.count_in;
                cur_pos = rq.start_in;
                due_ms = now_ms;
            end
            REQ_STATUS: begin
                st = '0;
                st.out_mode  = cur_mode;
                st.out_start = loop_start;
                st.out_end   = loop_end;
                st.out_count = loops_to_go;
                st.out_pos   = cur_pos;
                push_result(KIND_STATUS, st);
            end
            REQ_SET_LED: begin
                led_sel = rq.led_in;
            end
            REQ_STOP: begin
                cur_mode = 8'd0;
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge aclk) begin : watch
        owed_result_t due;
        res_t         got;
        if (!aresetn) begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                pattern[i] = '0;
            cur_mode    = 8'd0;
            cur_pos     = 8'd0;
            loop_start  = 8'd0;
            loop_end    = 8'(TABLE_DEPTH);
            loops_to_go = 8'd0;
            led_sel     = 8'd0;
            now_ms      = 32'd0;
            due_ms      = 32'd0;
            ms_unit     = MS_PER_FADE_RESET;
            owed_results.delete();
        end else begin
            // a result accepted here comes from an earlier item, so check before predicting
            if (m_tvalid && m_tready) begin
                got = res_t'(m_tdata);
                if (owed_results.size() == 0) begin
                    report_mismatch($sformatf("result kind %0d with nothing expected",
                                              m_tuser));
                end else begin
                    due = owed_results.pop_front();
                    check_field("kind",  int'(m_tuser),      int'(due.kind));
                    check_field("red",   int'(got.out_red),   int'(due.data.out_red));
                    check_field("green", int'(got.out_green), int'(due.data.out_green));
                    check_field("blue",  int'(got.out_blue),  int'(due.data.out_blue));
                    check_field("fade",  int'(got.out_fade),  int'(due.data.out_fade));
                    check_field("led",   int'(got.out_led),   int'(due.data.out_led));
                    check_field("mode",  int'(got.out_mode),  int'(due.data.out_mode));
                    check_field("start", int'(got.out_start), int'(due.data.out_start));
                    check_field("end",   int'(got.out_end),   int'(due.data.out_end));
                    check_field("count", int'(got.out_count), int'(due.data.out_count));
                    check_field("pos",   int'(got.out_pos),   int'(due.data.out_pos));
                end
            end
            if (s_tvalid && s_tready)
                predict_request(req_e'(s_tuser), req_t'(s_tdata));
            if (psel && penable && pready && paddr == MS_UNIT_ADDR) begin
                if (pwrite)
                    ms_unit = pwdata[7:0];
                else
                    check_field("ms_per_fade_unit readback", int'(prdata), int'(ms_unit));
            end
        end
        expected_left = owed_results.size();
    end

endmodule

// ===== bench/led_pattern_sequencer_core_tb.sv =====
// testbench top for the led pattern sequencer: stimulus, stall patterns and verdict
`timescale 1ns / 1ps

module led_pattern_sequencer_core_tb;

    import lps_pkg::*;

    localparam int TABLE_DEPTH     = 32;
    localparam int ITEMS_PER_PHASE = 420;
    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 8;
    localparam logic [CFG_ADDR_W-1:0] MS_UNIT_ADDR = CFG_ADDR_W'(4 * REG_MS_PER_FADE_UNIT);

    logic                   aclk;
    logic                   aresetn;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic [IN_USER_W-1:0]   s_tuser;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic [OUT_USER_W-1:0]  m_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [CFG_ADDR_W-1:0]  paddr;
    logic [CFG_DATA_W-1:0]  pwdata;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;

    int unsigned expected_left;
    int          fail_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_off;
    int          idle_cycles;

    req_e kind;
    req_t rq;

    led_pattern_sequencer_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    led_pattern_sequencer_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .expected_left(expected_left), .fail_count(fail_count)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // result side: random stalls, or a long hold-off while hold_off is set
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off)
                m_tready <= 1'b0;
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic req_t rand_payload();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return req_t'(raw[IN_DATA_W-1:0]);
    endfunction

    function automatic logic [7:0] table_pos();
        return ($urandom_range(99) < 85) ? 8'($urandom_range(TABLE_DEPTH - 1)) : 8'($urandom);
    endfunction

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic send_req(input req_e req, input req_t body);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= body;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_plain(input req_e req);
        send_req(req, rand_payload());
    endtask

    task automatic send_write(input logic [7:0] pos, input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic [15:0] fade);
        req_t body;
        body = rand_payload();
        body.position  = pos;
        body.red       = r;
        body.green     = g;
        body.blue      = b;
        body.fade_time = fade;
        send_req(REQ_WRITE, body);
    endtask

    task automatic send_read(input logic [7:0] pos);
        req_t body;
        body = rand_payload();
        body.position = pos;
        send_req(REQ_READ, body);
    endtask

    task automatic send_play(input logic [7:0] mode, input logic [7:0] first,
                             input logic [7:0] last, input logic [7:0] loops);
        req_t body;
        body = rand_payload();
        body.mode_in  = mode;
        body.start_in = first;
        body.end_in   = last;
        body.count_in = loops;
        send_req(REQ_PLAY, body);
    endtask

    task automatic send_led(input logic [7:0] led);
        req_t body;
        body = rand_payload();
        body.led_in = led;
        send_req(REQ_SET_LED, body);
    endtask

    // mostly small fades and in-table positions so the player runs through many lines
    task automatic next_random(output req_e req, output req_t body);
        int unsigned pick;
        pick = $urandom_range(99);
        body = rand_payload();
        if (pick < 45) begin
            req = REQ_TICK;
        end else if (pick < 62) begin
            req = REQ_WRITE;
            body.position = table_pos();
            body.fade_time = ($urandom_range(9) < 7) ? 16'($urandom_range(3)) :
                             ($urandom_range(2) < 2) ? 16'($urandom_range(50)) : 16'($urandom);
            if ($urandom_range(9) == 0)
                {body.red, body.green, body.blue, body.fade_time} = '0;
        end else if (pick < 70) begin
            req = REQ_READ;
            body.position = table_pos();
        end else if (pick < 77) begin
            req = REQ_PLAY;
            body.mode_in  = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(255, 1));
            body.start_in = table_pos();
            body.end_in   = ($urandom_range(9) < 8) ? 8'($urandom_range(40)) : 8'($urandom);
            body.count_in = ($urandom_range(9) < 8) ? 8'($urandom_range(4)) : 8'($urandom);
        end else if (pick < 85) begin
            req = REQ_STATUS;
        end else if (pick < 91) begin
            req = REQ_SET_LED;
        end else if (pick < 94) begin
            req = REQ_STOP;
        end else begin
            req = REQ_UNUSED;
        end
    endtask

    // called at a falling edge, returns at the falling edge after the one that drops psel
    task automatic apb_access(input logic is_write, input logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= MS_UNIT_ADDR;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    // the block may still be executing an item without a result after the last one arrives
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_left != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = REQ_TICK;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part at the reset fade unit
        send_plain(REQ_STATUS);
        send_read(8'd0);
        send_read(8'd255);
        send_led(8'hFF);
        send_write(8'd31, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
        send_led(8'hA5);
        // out of range position lands on line 0
        send_write(8'd200, 8'h5A, 8'hC3, 8'h0F, 16'd0);
        send_led(8'd0);
        send_write(8'd1, 8'd1, 8'd0, 8'd0, 16'd0);
        send_write(8'd2, 8'd0, 8'd0, 8'd0, 16'd0);
        send_read(8'd31);
        send_read(8'd0);
        send_plain(REQ_UNUSED);
        // two loops over lines 0..2, the zero line skipped
        send_play(8'hFF, 8'd0, 8'd2, 8'd2);
        repeat (7) send_plain(REQ_TICK);
        send_plain(REQ_STATUS);
        // mode zero keeps the player off but stores the bounds
        send_play(8'd0, 8'hFF, 8'hFF, 8'hFF);
        send_plain(REQ_STATUS);
        // start outside the table, end at table end, endless
        send_play(8'd1, 8'd250, 8'd0, 8'd0);
        repeat (3) send_plain(REQ_TICK);
        send_plain(REQ_STOP);
        send_plain(REQ_STATUS);

        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    apb_access(1'b1, 32'd1);
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    apb_access(1'b1, 32'd0);
                    send_idle_pct = 80;
                    recv_stall_pct = 0;
                end
                2: begin
                    apb_access(1'b1, 32'd255);
                    send_idle_pct = 0;
                    recv_stall_pct = 80;
                end
                default: begin
                    apb_access(1'b1, 32'd2);
                    send_idle_pct = 22;
                    recv_stall_pct = 22;
                end
            endcase
            apb_access(1'b0, 32'd0);
            if (ph == 0) begin
                // results back up behind a long receiver hold-off
                fork
                    begin
                        @(posedge aclk);
                        hold_off = 1'b1;
                        repeat (HOLD_CYCLES) @(posedge aclk);
                        hold_off = 1'b0;
                    end
                    begin
                        repeat (24)
                            send_req(($urandom_range(1) == 1) ? REQ_READ : REQ_STATUS,
                                     rand_payload());
                    end
                join
            end
            repeat (ITEMS_PER_PHASE) begin
                next_random(kind, rq);
                send_req(kind, rq);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== led_pattern_sequencer_core.f =====
sv/lps_pkg.sv
sv/lps_table.sv
sv/lps_ctrl.sv
sv/lps_datapath.sv
sv/led_pattern_sequencer_core.sv
bench/led_pattern_sequencer_checker.sv
bench/led_pattern_sequencer_core_tb.sv
